// File: src/amaf_pkg.sv
`default_nettype none

package amaf_pkg;

  // field widths
  localparam int unsigned RAW_W  = 16;
  localparam int unsigned CNT_W  = 14;
  localparam int unsigned NOW_W  = 18;
  localparam int unsigned MEAN_W = 19;
  localparam int unsigned OFS_W  = 18;
  localparam int unsigned RNG_W  = 2;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned AXES   = 3;

  // standard gravity in milli-m/s^2 per g, and the product width
  // one spare sign bit keeps the 2g slice inside the product
  localparam int unsigned GRAV_W     = 15;
  localparam int unsigned PROD_W     = CNT_W + GRAV_W + 1;
  localparam int unsigned GRAV_MILLI = 9807;

  // full scale codes, anything above 4g behaves as 8g
  localparam logic [RNG_W-1:0] RANGE_2G = 2'd0;
  localparam logic [RNG_W-1:0] RANGE_4G = 2'd1;

  // right shift applied to count * gravity per full scale
  localparam int unsigned SHIFT_2G = 12;
  localparam int unsigned SHIFT_4G = 11;
  localparam int unsigned SHIFT_8G = 10;

  // register indexes on the configuration port
  localparam logic [IDX_W-1:0] CFG_RANGE    = 2'd0;
  localparam logic [IDX_W-1:0] CFG_OFFSET_X = 2'd1;
  localparam logic [IDX_W-1:0] CFG_OFFSET_Y = 2'd2;
  localparam logic [IDX_W-1:0] CFG_OFFSET_Z = 2'd3;

endpackage

`default_nettype wire

// File: src/accel_moving_average_filter_unit.sv
// Three-axis accelerometer boxcar filter.
// Input channel: one word carries raw_x/y/z_word_i, left-justified 14-bit
// readings, taken at an edge with in_valid_i high and in_stall_o low.
// Output channel: one word per input word, mean_x/y/z_o (window mean minus
// offset) and now_x/y/z_o (converted sample), both in milli-m/s^2, taken
// at an edge with out_valid_o high and out_stall_i low.
// Config channel: cfg_index_i selects range_mode (0) or offset x/y/z (1..3);
// cfg_ready_o is always high. Write only while the filter is drained.
// Throughput: one word per cycle while out_stall_i is low, set by a
// four-register pipeline (input, convert, running sum, mean) that each word
// passes in order; the ring memory is read one slot ahead so its registered
// read fits the same rate.
// Reset: range is 4g, offsets are zero, rings and sums count as zero.
// No clearing pass: a fill flag masks ring slots not written since reset.
// When the receiver stalls, the pipeline keeps filling its empty stages and
// raises in_stall_o only once every stage holds a word.
`default_nettype none

module accel_moving_average_filter_unit #(
  parameter int unsigned WINDOW_LENGTH = 8
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // input channel
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire  signed [amaf_pkg::RAW_W-1:0]   raw_x_word_i,
  input  wire  signed [amaf_pkg::RAW_W-1:0]   raw_y_word_i,
  input  wire  signed [amaf_pkg::RAW_W-1:0]   raw_z_word_i,
  // output channel
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic signed [amaf_pkg::MEAN_W-1:0]  mean_x_o,
  output logic signed [amaf_pkg::MEAN_W-1:0]  mean_y_o,
  output logic signed [amaf_pkg::MEAN_W-1:0]  mean_z_o,
  output logic signed [amaf_pkg::NOW_W-1:0]   now_x_o,
  output logic signed [amaf_pkg::NOW_W-1:0]   now_y_o,
  output logic signed [amaf_pkg::NOW_W-1:0]   now_z_o,
  // configuration channel
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire         [amaf_pkg::IDX_W-1:0]   cfg_index_i,
  input  wire         [amaf_pkg::OFS_W-1:0]   cfg_data_i
);

  import amaf_pkg::*;

  // window sizing
  localparam int unsigned LOG_N    = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 0;
  localparam int unsigned SLOT_W   = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int unsigned SUM_W    = NOW_W + LOG_N;
  localparam int unsigned MAG_W    = SUM_W - 1;
  // reciprocal of the window length, exact for magnitudes below 2^MAG_W
  localparam int unsigned RECIP_SH = MAG_W + LOG_N;
  localparam int unsigned RECIP_W  = RECIP_SH + 1;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << RECIP_SH) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
  localparam int unsigned MUL_W    = MAG_W + RECIP_W;
  localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(WINDOW_LENGTH - 1);

  // configuration registers
  logic [RNG_W-1:0]        range_q;
  logic signed [OFS_W-1:0] ofs_q [AXES];

  // pipeline valids and ready chain
  logic v0_q, v1_q, v2_q, v3_q;
  logic rdy0, rdy1, rdy2, rdy3;
  logic step;

  // pipeline data
  logic signed [RAW_W-1:0]  raw0_q [AXES];
  logic signed [NOW_W-1:0]  now1_d [AXES];
  logic signed [NOW_W-1:0]  now1_q [AXES];
  logic signed [NOW_W-1:0]  now2_q [AXES];
  logic signed [MEAN_W-1:0] mean3_d [AXES];
  logic signed [MEAN_W-1:0] mean3_q [AXES];
  logic signed [NOW_W-1:0]  now3_q [AXES];

  // window state
  logic [AXES-1:0][NOW_W-1:0] ring_mem [WINDOW_LENGTH];
  logic [AXES-1:0][NOW_W-1:0] rd_q;
  logic [AXES-1:0][NOW_W-1:0] wr_row;
  logic signed [SUM_W-1:0]    sum_q [AXES];
  logic signed [SUM_W-1:0]    sum_d [AXES];
  logic [SLOT_W-1:0]          slot_q;
  logic [SLOT_W-1:0]          slot_nxt;
  logic                       wrap;
  logic                       full_q;

  // config write, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= RANGE_4G;
      for (int a = 0; a < AXES; a++) begin
        ofs_q[a] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_RANGE:    range_q  <= cfg_data_i[RNG_W-1:0];
        CFG_OFFSET_X: ofs_q[0] <= $signed(cfg_data_i);
        CFG_OFFSET_Y: ofs_q[1] <= $signed(cfg_data_i);
        CFG_OFFSET_Z: ofs_q[2] <= $signed(cfg_data_i);
        default:      range_q  <= range_q;
      endcase
    end
  end

  // ready chain: a stage takes a word when empty or when it moves on
  assign rdy3       = !v3_q || !out_stall_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign rdy0       = !v0_q || rdy1;
  assign in_stall_o = !rdy0;
  assign step       = v1_q && rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= in_valid_i;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (rdy0) begin
      raw0_q[0] <= raw_x_word_i;
      raw0_q[1] <= raw_y_word_i;
      raw0_q[2] <= raw_z_word_i;
    end
  end

  // convert: drop two low bits, scale by gravity, shift per full scale
  always_comb begin
    logic signed [PROD_W-1:0] prod;
    for (int a = 0; a < AXES; a++) begin
      prod = PROD_W'($signed(raw0_q[a][RAW_W-1 -: CNT_W]))
           * $signed(PROD_W'(GRAV_MILLI));
      case (range_q)
        RANGE_2G: now1_d[a] = prod[SHIFT_2G +: NOW_W];
        RANGE_4G: now1_d[a] = prod[SHIFT_4G +: NOW_W];
        default:  now1_d[a] = prod[SHIFT_8G +: NOW_W];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      now1_q <= now1_d;
    end
  end

  // slot bookkeeping
  assign wrap     = (slot_q == SLOT_MAX);
  assign slot_nxt = wrap ? '0 : slot_q + 1'b1;

  // running sum update, oldest entry comes from the prefetched slot
  always_comb begin
    logic signed [SUM_W-1:0] old;
    for (int a = 0; a < AXES; a++) begin
      if (WINDOW_LENGTH == 1) begin
        old = sum_q[a];
      end else if (full_q) begin
        old = SUM_W'($signed(rd_q[a]));
      end else begin
        old = '0;
      end
      sum_d[a]  = sum_q[a] + SUM_W'(now1_q[a]) - old;
      wr_row[a] = now1_q[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      full_q <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        sum_q[a] <= '0;
      end
    end else if (step) begin
      slot_q <= slot_nxt;
      if (wrap) full_q <= 1'b1;
      sum_q  <= sum_d;
    end
  end

  // ring memory, write current slot and read the next one ahead
  always_ff @(posedge clk_i) begin
    if (step) begin
      ring_mem[slot_q] <= wr_row;
      rd_q             <= ring_mem[slot_nxt];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      now2_q <= now1_q;
    end
  end

  // mean by reciprocal multiply on the magnitude, then subtract offset
  always_comb begin
    logic              neg;
    logic [SUM_W-1:0]  mag_full;
    logic [MUL_W-1:0]  mul;
    logic [NOW_W-1:0]  quo;
    logic signed [NOW_W-1:0] mean;
    for (int a = 0; a < AXES; a++) begin
      neg      = sum_q[a][SUM_W-1];
      mag_full = neg ? (-sum_q[a]) : sum_q[a];
      mul      = MUL_W'(mag_full[MAG_W-1:0]) * MUL_W'(RECIP);
      quo      = mul[RECIP_SH +: NOW_W];
      mean     = neg ? -$signed(quo) : $signed(quo);
      mean3_d[a] = MEAN_W'(mean) - MEAN_W'(ofs_q[a]);
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      mean3_q <= mean3_d;
      now3_q  <= now2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign mean_x_o    = mean3_q[0];
  assign mean_y_o    = mean3_q[1];
  assign mean_z_o    = mean3_q[2];
  assign now_x_o     = now3_q[0];
  assign now_y_o     = now3_q[1];
  assign now_z_o     = now3_q[2];

  // write slot never leaves the window
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_MAX)
    else $error("write slot beyond window");

  // once the ring has wrapped every slot holds data for good
  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |=> full_q)
    else $error("fill flag dropped");

  // a step on the last slot marks the ring full
  a_full_on_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && wrap) |=> full_q)
    else $error("ring wrap did not mark full");

  // a word leaving the sum stage shows up on the output next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && rdy3) |=> out_valid_o)
    else $error("result word lost");

  // an empty input register never stalls the sender
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v0_q |-> !in_stall_o)
    else $error("stall with empty input stage");

endmodule

`default_nettype wire

// File: dv/amaf_filter_checker.sv
`timescale 1ns / 1ps

module amaf_filter_checker #(
  parameter int WINDOW_LENGTH = 8
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // input channel
  input  wire                                 in_valid_i,
  input  wire                                 in_stall_o,
  input  wire         [amaf_pkg::RAW_W-1:0]   raw_x_word_i,
  input  wire         [amaf_pkg::RAW_W-1:0]   raw_y_word_i,
  input  wire         [amaf_pkg::RAW_W-1:0]   raw_z_word_i,
  // output channel
  input  wire                                 out_valid_o,
  input  wire                                 out_stall_i,
  input  wire  signed [amaf_pkg::MEAN_W-1:0]  mean_x_o,
  input  wire  signed [amaf_pkg::MEAN_W-1:0]  mean_y_o,
  input  wire  signed [amaf_pkg::MEAN_W-1:0]  mean_z_o,
  input  wire  signed [amaf_pkg::NOW_W-1:0]   now_x_o,
  input  wire  signed [amaf_pkg::NOW_W-1:0]   now_y_o,
  input  wire  signed [amaf_pkg::NOW_W-1:0]   now_z_o,
  // configuration channel
  input  wire                                 cfg_valid_i,
  input  wire                                 cfg_ready_o,
  input  wire         [amaf_pkg::IDX_W-1:0]   cfg_index_i,
  input  wire         [amaf_pkg::OFS_W-1:0]   cfg_data_i,
  // status for the testbench top
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  checked_o
);

  import amaf_pkg::*;

  localparam int MILLI_PER_G = 9807;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean_x;
    logic signed [MEAN_W-1:0] mean_y;
    logic signed [MEAN_W-1:0] mean_z;
    logic signed [NOW_W-1:0]  now_x;
    logic signed [NOW_W-1:0]  now_y;
    logic signed [NOW_W-1:0]  now_z;
  } accel_sample_t;

  // shadow of the filter registers and window state
  logic [RNG_W-1:0] range_sel;
  int               ofs [AXES];
  int               ring [AXES][WINDOW_LENGTH];
  int               run_sum [AXES];
  int               slot;

  accel_sample_t    expected_q [$];
  accel_sample_t    want;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic signed [MEAN_W-1:0] got,
                             input logic signed [MEAN_W-1:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("word %0d %s got %0d want %0d", checked_o, name, got,
                                exp_val));
  endtask

  // raw left-justified word to milli-m/s^2, floor shift per full scale
  function automatic int to_milli(input logic [RAW_W-1:0] raw);
    int count;
    int product;
    count   = $signed(raw[RAW_W-1:2]);
    product = count * MILLI_PER_G;
    case (range_sel)
      RANGE_2G: return product >>> SHIFT_2G;
      RANGE_4G: return product >>> SHIFT_4G;
      default:  return product >>> SHIFT_8G;
    endcase
  endfunction

  // push one sample through the boxcar window and form the result word
  task automatic advance_window(input logic [RAW_W-1:0] rx, ry, rz,
                                output accel_sample_t res);
    logic [RAW_W-1:0] raw_v [AXES];
    int               now_v [AXES];
    int               mean_v [AXES];
    raw_v[0] = rx;
    raw_v[1] = ry;
    raw_v[2] = rz;
    for (int a = 0; a < AXES; a++) begin
      now_v[a]      = to_milli(raw_v[a]);
      run_sum[a]    = run_sum[a] + now_v[a] - ring[a][slot];
      ring[a][slot] = now_v[a];
      // signed division truncates toward zero
      mean_v[a]     = run_sum[a] / WINDOW_LENGTH - ofs[a];
    end
    slot = (slot == WINDOW_LENGTH - 1) ? 0 : slot + 1;
    res.mean_x = mean_v[0];
    res.mean_y = mean_v[1];
    res.mean_z = mean_v[2];
    res.now_x  = now_v[0];
    res.now_y  = now_v[1];
    res.now_z  = now_v[2];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_sel = RANGE_4G;
      slot      = 0;
      for (int a = 0; a < AXES; a++) begin
        ofs[a]     = 0;
        run_sum[a] = 0;
        for (int i = 0; i < WINDOW_LENGTH; i++) ring[a][i] = 0;
      end
      expected_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_RANGE:    range_sel = cfg_data_i[RNG_W-1:0];
          CFG_OFFSET_X: ofs[0] = $signed(cfg_data_i);
          CFG_OFFSET_Y: ofs[1] = $signed(cfg_data_i);
          CFG_OFFSET_Z: ofs[2] = $signed(cfg_data_i);
          default: ;
        endcase
      end
      // result words against the oldest prediction
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result word with nothing outstanding, mean_x %0d",
                                    mean_x_o));
        end else begin
          want = expected_q.pop_front();
          check_field("mean_x", mean_x_o, want.mean_x);
          check_field("mean_y", mean_y_o, want.mean_y);
          check_field("mean_z", mean_z_o, want.mean_z);
          check_field("now_x", now_x_o, want.now_x);
          check_field("now_y", now_y_o, want.now_y);
          check_field("now_z", now_z_o, want.now_z);
          checked_o++;
        end
      end
      // sample words into the predictor
      if (in_valid_i && !in_stall_o) begin
        advance_window(raw_x_word_i, raw_y_word_i, raw_z_word_i, want);
        expected_q.push_back(want);
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// File: dv/accel_moving_average_filter_unit_tb.sv
`timescale 1ns / 1ps

module accel_moving_average_filter_unit_tb;

  import amaf_pkg::*;

  localparam int WINDOW_LENGTH = 8;
  localparam int WORDS_TARGET  = 1150;
  // worst quiet stretch is a long sender gap plus a long stall plus the pipe
  localparam int IDLE_LIMIT    = 1000;
  localparam int SETTLE_CYCLES = 8;

  localparam logic [RNG_W-1:0] RANGE_RSVD = 2'd3;
  localparam logic [OFS_W-1:0] OFS_MAX    = 18'h1ffff;
  localparam logic [OFS_W-1:0] OFS_MIN    = 18'h20000;
  localparam logic [RAW_W-1:0] RAW_MAX    = 16'h7fff;
  localparam logic [RAW_W-1:0] RAW_MIN    = 16'h8000;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [RAW_W-1:0]  raw_x_word_i;
  logic signed [RAW_W-1:0]  raw_y_word_i;
  logic signed [RAW_W-1:0]  raw_z_word_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [MEAN_W-1:0] mean_x_o;
  logic signed [MEAN_W-1:0] mean_y_o;
  logic signed [MEAN_W-1:0] mean_z_o;
  logic signed [NOW_W-1:0]  now_x_o;
  logic signed [NOW_W-1:0]  now_y_o;
  logic signed [NOW_W-1:0]  now_z_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [IDX_W-1:0]         cfg_index_i;
  logic [OFS_W-1:0]         cfg_data_i;

  int fail_count_o;
  int pending_o;
  int checked_o;

  int words_sent;
  int cfg_writes;
  int settings;
  int idle_cycles;
  bit quiet;

  accel_moving_average_filter_unit #(.WINDOW_LENGTH(WINDOW_LENGTH)) uut (.*);

  amaf_filter_checker #(.WINDOW_LENGTH(WINDOW_LENGTH)) chk (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3, 4: return RAW_W'($urandom);
      5, 6:          return RAW_W'($urandom_range(0, 255)) - RAW_W'(128);
      7:             return $urandom_range(0, 1) ? RAW_MAX : RAW_MIN;
      8:             return $urandom_range(0, 1) ? RAW_MAX - RAW_W'($urandom_range(0, 7))
                                                 : RAW_MIN + RAW_W'($urandom_range(0, 7));
      default:       return RAW_W'($urandom_range(0, 7)) - RAW_W'(4);
    endcase
  endfunction

  function automatic logic [OFS_W-1:0] pick_offset();
    int r;
    r = $urandom_range(0, 7);
    case (r)
      0:       return OFS_MAX;
      1:       return OFS_MIN;
      2:       return '0;
      3:       return OFS_W'($urandom_range(0, 4000)) - OFS_W'(2000);
      default: return OFS_W'($urandom);
    endcase
  endfunction

  // receiving side: bursts of stall, quiet phases never stall
  initial begin : rx_side
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (quiet) begin
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        n = pick_gap();
        repeat (n) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
        n = $urandom_range(1, 8);
        repeat (n) begin
          @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // watchdog on cycles with no word or register write taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] watchdog: no progress, %0d results outstanding", $time, pending_o);
        $display("accel_moving_average_filter_unit_tb: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // valid stays high across back-to-back words
  task automatic send_word(input logic [RAW_W-1:0] x, y, z);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    raw_x_word_i <= x;
    raw_y_word_i <= y;
    raw_z_word_i <= z;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  // drop valid and wait until every result word is back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_o != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [OFS_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_writes++;
  endtask

  task automatic set_filter(input logic [RNG_W-1:0] rng, input logic [OFS_W-1:0] ox, oy, oz);
    // unused upper data bits of the range write carry noise
    write_reg(CFG_RANGE, {(OFS_W-RNG_W)'($urandom), rng});
    write_reg(CFG_OFFSET_X, ox);
    write_reg(CFG_OFFSET_Y, oy);
    write_reg(CFG_OFFSET_Z, oz);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  initial begin : stimulus
    int                n;
    int                phase;
    logic [RNG_W-1:0]  rng;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    raw_x_word_i = '0;
    raw_y_word_i = '0;
    raw_z_word_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_RANGE;
    cfg_data_i   = '0;
    quiet        = 1'b0;
    words_sent   = 0;
    cfg_writes   = 0;
    settings     = 1;
    idle_cycles  = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // warm-up at reset settings, extremes and dropped low bits, window wrap
    send_word(RAW_MAX, RAW_MIN, 16'h0000);
    send_word(RAW_MIN, RAW_MAX, 16'hffff);
    send_word(16'h0003, 16'hfffc, 16'h0004);
    send_word(16'hffff, 16'h0001, 16'h4000);
    send_word(16'hc000, 16'h3fff, 16'hfffd);
    send_word(RAW_MAX, RAW_MAX, RAW_MAX);
    send_word(RAW_MIN, RAW_MIN, RAW_MIN);
    send_word(16'h0004, 16'hfffb, 16'h2aaa);
    send_word(16'hd555, 16'h5554, 16'h8001);
    drain();

    // 2g with offsets at both ends
    set_filter(RANGE_2G, OFS_MAX, OFS_MIN, '0);
    send_word(RAW_MAX, RAW_MIN, 16'hffff);
    send_word(RAW_MAX, RAW_MIN, 16'hffff);
    send_word(RAW_MIN, RAW_MAX, 16'h0003);
    send_word(RAW_MIN, RAW_MAX, 16'h0003);
    drain();

    // reserved range code acts as 8g; a full window drives the means to their limits
    set_filter(RANGE_RSVD, OFS_MAX, OFS_MIN, OFS_MAX);
    repeat (WINDOW_LENGTH) send_word(RAW_MIN, RAW_MAX, RAW_MIN);
    drain();

    // random phases, each with its own setting and idling mode
    phase = 0;
    while (words_sent < WORDS_TARGET) begin
      rng = (phase < 4) ? RNG_W'(phase) : RNG_W'($urandom_range(0, 3));
      set_filter(rng, pick_offset(), pick_offset(), pick_offset());
      quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(40, 150);
      repeat (n) send_word(pick_raw(), pick_raw(), pick_raw());
      drain();
      phase++;
    end
    quiet = 1'b0;

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d sample words over %0d filter settings, %0d register writes",
             words_sent, settings, cfg_writes);
    $display("%0d result words compared, range codes 2g/4g/8g/reserved, offset extremes",
             checked_o);
    if (fail_count_o == 0 && pending_o == 0) begin
      $display("accel_moving_average_filter_unit_tb: clean");
    end else begin
      $display("accel_moving_average_filter_unit_tb: errors");
    end
    $finish;
  end

endmodule

// File: accel_moving_average_filter_unit.f
src/amaf_pkg.sv
src/accel_moving_average_filter_unit.sv
dv/amaf_filter_checker.sv
dv/accel_moving_average_filter_unit_tb.sv
